// ----- hdl/ultrasonic_echo_median_ranger_defines.svh -----
// Assertion macros used by the ranger top level.
`ifndef ULTRASONIC_ECHO_MEDIAN_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_MEDIAN_RANGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define UEMR_ASSERT_SAME(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error(msg);
`define UEMR_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error(msg);
`else
`define UEMR_ASSERT_SAME(name, clk, rstn, pre, post, msg)
`define UEMR_ASSERT_NEXT(name, clk, rstn, pre, post, msg)
`endif

`endif

// ----- hdl/uemr_pkg.sv -----
// Package with types, constants and helpers of the ultrasonic ranger.
`timescale 1ns / 1ps

package uemr_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int NUM_W       = IDX_W + 1;
  localparam int CNT_W       = 16;
  localparam int CM_W        = 10;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CM_W-1:0]  CM_MAX  = {CM_W{1'b1}};

  // Division by 58 as a multiply by the scaled reciprocal, exact for 16-bit pulses.
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 17'd72316;
  localparam int PROD_W      = CNT_W + RECIP_W;
  localparam int QUOT_W      = 11;

  localparam logic [NUM_W-1:0] RST_SAMPLE_COUNT = 5'd5;
  localparam logic [CM_W-1:0]  RST_MIN_CM       = 10'd2;
  localparam logic [CM_W-1:0]  RST_MAX_CM       = 10'd400;
  localparam logic [CM_W-1:0]  RST_DEFAULT_CM   = 10'd400;
  localparam logic [15:0]      RST_RISE_TIMEOUT = 16'd30000;
  localparam logic [15:0]      RST_PULSE_TIMEOUT = 16'd25000;
  localparam logic [7:0]       RST_TRIGGER_US   = 8'd10;
  localparam logic [15:0]      RST_GAP_US       = 16'd15000;

  typedef struct packed {
    logic start_req;
    logic echo;
  } item_t;

  typedef struct packed {
    logic             trigger;
    logic             busy_res;
    logic             done_res;
    logic [CM_W-1:0]  distance_cm;
    logic             fell_back;
    logic [NUM_W-1:0] valid_count;
  } result_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_RISE = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_e;

  typedef enum logic [6:0] {
    SQ_READY = 7'b0000001,
    SQ_DIV   = 7'b0000010,
    SQ_CHK   = 7'b0000100,
    SQ_RD    = 7'b0001000,
    SQ_CMP   = 7'b0010000,
    SQ_PUT   = 7'b0100000,
    SQ_MED   = 7'b1000000
  } seq_e;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT  = 3'd0,
    REG_MIN_CM        = 3'd1,
    REG_MAX_CM        = 3'd2,
    REG_DEFAULT_CM    = 3'd3,
    REG_RISE_TIMEOUT  = 3'd4,
    REG_PULSE_TIMEOUT = 3'd5,
    REG_TRIGGER_US    = 3'd6,
    REG_GAP_US        = 3'd7
  } reg_e;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ----- hdl/uemr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module uemr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/ultrasonic_echo_median_ranger.sv -----
// Top level of the ultrasonic ranger with a sorted reading store and median pick.
//
// Each item on item_i is one microsecond tick: the sampled echo level and a
// start request. An item is accepted at a clock edge with start_i high and
// busy_o low. Every accepted item gives exactly one result on result_o, shown
// for one cycle with done_o high; the receiver takes it at once and cannot
// stall it. For most ticks the result appears the cycle after the item and
// busy_o stays low. A tick that ends a reading still gives its result the
// next cycle, but busy_o stays high while the pulse is divided by 58 through
// one registered multiply and the value is insertion-sorted into the reading
// store over one RAM read port and one write port. A rejected reading only
// passes the divide and check states; a kept one shifts each larger stored
// reading up and is written into the gap. The final tick of a measurement
// reads the middle entry through one registered read. Configuration goes
// over APB at byte address 4*index; the user must write it only while no
// measurement runs, which the block does not enforce. Reset returns the
// registers to their defaults and the sequencer to idle; the reading store
// needs no clearing since only sorted entries below the valid count are read.
`timescale 1ns / 1ps
`include "ultrasonic_echo_median_ranger_defines.svh"

module ultrasonic_echo_median_ranger (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  uemr_pkg::item_t                      item_i,
  output logic                                 done_o,
  output uemr_pkg::result_t                    result_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [uemr_pkg::ADDR_W-1:0]          paddr,
  input  logic [uemr_pkg::DATA_W-1:0]          pwdata,
  output logic [uemr_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  logic [uemr_pkg::NUM_W-1:0] sample_count_q;
  logic [uemr_pkg::CM_W-1:0]  min_cm_q;
  logic [uemr_pkg::CM_W-1:0]  max_cm_q;
  logic [uemr_pkg::CM_W-1:0]  default_cm_q;
  logic [15:0]                rise_to_q;
  logic [15:0]                pulse_to_q;
  logic [7:0]                 trigger_us_q;
  logic [15:0]                gap_us_q;

  uemr_pkg::phase_e           phase_q, phase_d;
  uemr_pkg::seq_e             state_q, state_d;
  logic [uemr_pkg::CNT_W-1:0] tick_q, tick_d;
  logic [uemr_pkg::NUM_W-1:0] ridx_q, ridx_d;
  logic [uemr_pkg::NUM_W-1:0] vr_q, vr_d;
  logic [uemr_pkg::IDX_W-1:0] j_q, j_d;
  logic [uemr_pkg::CNT_W-1:0] pulse_q, pulse_d;
  logic [uemr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [uemr_pkg::CM_W-1:0]  cm_q, cm_d;
  uemr_pkg::result_t          result_q, result_d;
  logic                       done_q, done_d;

  logic                       accept;
  logic                       cfg_we;
  logic                       vr_clr;
  logic                       trig;
  logic                       bres;
  logic                       fin;
  logic                       done_tick;
  logic [uemr_pkg::CNT_W-1:0] fin_pulse;
  logic [uemr_pkg::NUM_W-1:0] eff_samples;
  logic [uemr_pkg::QUOT_W-1:0] quot;
  logic [uemr_pkg::CM_W-1:0]  cm_sat;
  logic                       fallback;

  logic                       ram_we;
  logic [uemr_pkg::IDX_W-1:0] ram_waddr;
  logic [uemr_pkg::CM_W-1:0]  ram_wdata;
  logic [uemr_pkg::IDX_W-1:0] ram_raddr;
  logic [uemr_pkg::CM_W-1:0]  ram_rdata;

  assign busy_o   = (state_q != uemr_pkg::SQ_READY);
  assign accept   = start_i && !busy_o;
  assign done_o   = done_q;
  assign result_o = result_q;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && pready;

  always_comb begin
    if (sample_count_q == '0) begin
      eff_samples = uemr_pkg::NUM_W'(1);
    end else if (sample_count_q > uemr_pkg::NUM_W'(uemr_pkg::MAX_SAMPLES)) begin
      eff_samples = uemr_pkg::NUM_W'(uemr_pkg::MAX_SAMPLES);
    end else begin
      eff_samples = sample_count_q;
    end
  end

  always_comb begin
    case (uemr_pkg::reg_e'(paddr[4:2]))
      uemr_pkg::REG_SAMPLE_COUNT:  prdata = uemr_pkg::DATA_W'(sample_count_q);
      uemr_pkg::REG_MIN_CM:        prdata = uemr_pkg::DATA_W'(min_cm_q);
      uemr_pkg::REG_MAX_CM:        prdata = uemr_pkg::DATA_W'(max_cm_q);
      uemr_pkg::REG_DEFAULT_CM:    prdata = uemr_pkg::DATA_W'(default_cm_q);
      uemr_pkg::REG_RISE_TIMEOUT:  prdata = uemr_pkg::DATA_W'(rise_to_q);
      uemr_pkg::REG_PULSE_TIMEOUT: prdata = uemr_pkg::DATA_W'(pulse_to_q);
      uemr_pkg::REG_TRIGGER_US:    prdata = uemr_pkg::DATA_W'(trigger_us_q);
      uemr_pkg::REG_GAP_US:        prdata = uemr_pkg::DATA_W'(gap_us_q);
      default:                     prdata = '0;
    endcase
  end

  // Per-tick phase logic.
  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    ridx_d    = ridx_q;
    vr_clr    = 1'b0;
    trig      = 1'b0;
    bres      = 1'b1;
    fin       = 1'b0;
    fin_pulse = '0;
    done_tick = 1'b0;
    case (phase_q)
      uemr_pkg::PH_IDLE: begin
        bres = 1'b0;
        if (item_i.start_req) begin
          ridx_d  = '0;
          vr_clr  = 1'b1;
          phase_d = uemr_pkg::PH_TRIG;
          tick_d  = uemr_pkg::CNT_W'(1);
          trig    = 1'b1;
          bres    = 1'b1;
        end
      end
      uemr_pkg::PH_TRIG: begin
        if (tick_q < uemr_pkg::CNT_W'(trigger_us_q)) begin
          trig   = 1'b1;
          tick_d = uemr_pkg::cnt_inc(tick_q);
        end else if (item_i.echo) begin
          phase_d = uemr_pkg::PH_HIGH;
          tick_d  = uemr_pkg::CNT_W'(1);
        end else begin
          phase_d = uemr_pkg::PH_RISE;
          tick_d  = uemr_pkg::CNT_W'(1);
        end
      end
      uemr_pkg::PH_RISE: begin
        if (item_i.echo) begin
          phase_d = uemr_pkg::PH_HIGH;
          tick_d  = uemr_pkg::CNT_W'(1);
        end else if (tick_q > rise_to_q || tick_q == uemr_pkg::CNT_MAX) begin
          fin = 1'b1;
        end else begin
          tick_d = uemr_pkg::cnt_inc(tick_q);
        end
      end
      uemr_pkg::PH_HIGH: begin
        if (!item_i.echo) begin
          fin       = 1'b1;
          fin_pulse = tick_q;
        end else if (tick_q > pulse_to_q || tick_q == uemr_pkg::CNT_MAX) begin
          fin = 1'b1;
        end else begin
          tick_d = uemr_pkg::cnt_inc(tick_q);
        end
      end
      uemr_pkg::PH_GAP: begin
        if (tick_q < gap_us_q) begin
          tick_d = uemr_pkg::cnt_inc(tick_q);
        end else if (ridx_q < eff_samples) begin
          phase_d = uemr_pkg::PH_TRIG;
          tick_d  = uemr_pkg::CNT_W'(1);
          trig    = 1'b1;
        end else begin
          done_tick = 1'b1;
          bres      = 1'b0;
          phase_d   = uemr_pkg::PH_IDLE;
          tick_d    = '0;
        end
      end
      default: begin
        phase_d = uemr_pkg::PH_IDLE;
        tick_d  = '0;
        bres    = 1'b0;
      end
    endcase
    if (fin) begin
      ridx_d  = ridx_q + 1'b1;
      phase_d = uemr_pkg::PH_GAP;
      tick_d  = '0;
    end
  end

  assign quot     = prod_q[uemr_pkg::RECIP_SHIFT +: uemr_pkg::QUOT_W];
  assign cm_sat   = (quot > uemr_pkg::QUOT_W'(uemr_pkg::CM_MAX)) ? uemr_pkg::CM_MAX
                                                                : quot[uemr_pkg::CM_W-1:0];
  assign fallback = (vr_q < (eff_samples >> 1)) || (vr_q == '0);

  // Sequencer: divide, insertion sort into the store, median read.
  always_comb begin
    state_d   = state_q;
    vr_d      = vr_q;
    j_d       = j_q;
    pulse_d   = pulse_q;
    prod_d    = prod_q;
    cm_d      = cm_q;
    result_d  = result_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = j_q + 1'b1;
    ram_wdata = cm_q;
    ram_raddr = vr_q[uemr_pkg::NUM_W-1:1];
    case (state_q)
      uemr_pkg::SQ_READY: begin
        if (accept) begin
          if (vr_clr) begin
            vr_d = '0;
          end
          if (fin) begin
            pulse_d = fin_pulse;
            state_d = uemr_pkg::SQ_DIV;
          end
          if (done_tick) begin
            state_d = uemr_pkg::SQ_MED;
          end else begin
            result_d = '{trigger: trig, busy_res: bres, done_res: 1'b0,
                         distance_cm: '0, fell_back: 1'b0, valid_count: '0};
            done_d   = 1'b1;
          end
        end
      end
      uemr_pkg::SQ_DIV: begin
        prod_d  = uemr_pkg::PROD_W'(pulse_q) * uemr_pkg::PROD_W'(uemr_pkg::RECIP);
        state_d = uemr_pkg::SQ_CHK;
      end
      uemr_pkg::SQ_CHK: begin
        cm_d = cm_sat;
        if (cm_sat >= min_cm_q && cm_sat <= max_cm_q &&
            vr_q < uemr_pkg::NUM_W'(uemr_pkg::MAX_SAMPLES)) begin
          if (vr_q == '0) begin
            state_d = uemr_pkg::SQ_PUT;
          end else begin
            j_d     = vr_q[uemr_pkg::IDX_W-1:0] - 1'b1;
            state_d = uemr_pkg::SQ_RD;
          end
        end else begin
          state_d = uemr_pkg::SQ_READY;
        end
      end
      uemr_pkg::SQ_RD: begin
        ram_raddr = j_q;
        state_d   = uemr_pkg::SQ_CMP;
      end
      uemr_pkg::SQ_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > cm_q) begin
          ram_wdata = ram_rdata;
          if (j_q == '0) begin
            state_d = uemr_pkg::SQ_PUT;
          end else begin
            j_d     = j_q - 1'b1;
            state_d = uemr_pkg::SQ_RD;
          end
        end else begin
          vr_d    = vr_q + 1'b1;
          state_d = uemr_pkg::SQ_READY;
        end
      end
      uemr_pkg::SQ_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        vr_d      = vr_q + 1'b1;
        state_d   = uemr_pkg::SQ_READY;
      end
      uemr_pkg::SQ_MED: begin
        result_d = '{trigger: 1'b0, busy_res: 1'b0, done_res: 1'b1,
                     distance_cm: fallback ? default_cm_q : ram_rdata,
                     fell_back: fallback, valid_count: vr_q};
        done_d   = 1'b1;
        state_d  = uemr_pkg::SQ_READY;
      end
      default: begin
        state_d = uemr_pkg::SQ_READY;
      end
    endcase
  end

  uemr_ram #(
    .WIDTH(uemr_pkg::CM_W),
    .DEPTH(uemr_pkg::MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= uemr_pkg::RST_SAMPLE_COUNT;
      min_cm_q       <= uemr_pkg::RST_MIN_CM;
      max_cm_q       <= uemr_pkg::RST_MAX_CM;
      default_cm_q   <= uemr_pkg::RST_DEFAULT_CM;
      rise_to_q      <= uemr_pkg::RST_RISE_TIMEOUT;
      pulse_to_q     <= uemr_pkg::RST_PULSE_TIMEOUT;
      trigger_us_q   <= uemr_pkg::RST_TRIGGER_US;
      gap_us_q       <= uemr_pkg::RST_GAP_US;
    end else if (cfg_we) begin
      case (uemr_pkg::reg_e'(paddr[4:2]))
        uemr_pkg::REG_SAMPLE_COUNT:  sample_count_q <= pwdata[uemr_pkg::NUM_W-1:0];
        uemr_pkg::REG_MIN_CM:        min_cm_q       <= pwdata[uemr_pkg::CM_W-1:0];
        uemr_pkg::REG_MAX_CM:        max_cm_q       <= pwdata[uemr_pkg::CM_W-1:0];
        uemr_pkg::REG_DEFAULT_CM:    default_cm_q   <= pwdata[uemr_pkg::CM_W-1:0];
        uemr_pkg::REG_RISE_TIMEOUT:  rise_to_q      <= pwdata[15:0];
        uemr_pkg::REG_PULSE_TIMEOUT: pulse_to_q     <= pwdata[15:0];
        uemr_pkg::REG_TRIGGER_US:    trigger_us_q   <= pwdata[7:0];
        uemr_pkg::REG_GAP_US:        gap_us_q       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= uemr_pkg::PH_IDLE;
      state_q <= uemr_pkg::SQ_READY;
      tick_q  <= '0;
      ridx_q  <= '0;
      vr_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        ridx_q  <= ridx_d;
      end
      state_q <= state_d;
      vr_q    <= vr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    pulse_q  <= pulse_d;
    prod_q   <= prod_d;
    cm_q     <= cm_d;
    result_q <= result_d;
  end

  `UEMR_ASSERT_SAME(a_store_write_in_range, clk_i, rst_ni, ram_we,
                    (uemr_pkg::NUM_W'(ram_waddr) <= vr_q) &&
                    (vr_q < uemr_pkg::NUM_W'(uemr_pkg::MAX_SAMPLES)),
                    "store write beyond the sorted entries")
  `UEMR_ASSERT_SAME(a_median_has_readings, clk_i, rst_ni,
                    done_o && result_o.done_res && !result_o.fell_back,
                    result_o.valid_count != '0, "median given without a valid reading")
  `UEMR_ASSERT_NEXT(a_median_delivers, clk_i, rst_ni, state_q == uemr_pkg::SQ_MED,
                    done_o && result_o.done_res && !busy_o,
                    "median read did not deliver the final item")

endmodule
